// ===== hdl/dgm_pkg.sv =====
// Package for the diamond grid mesh generator: shared types and constants.
// No dependencies.
package dgm_pkg;

  localparam int unsigned SizeW  = 12;
  localparam int unsigned SegW   = 9;
  localparam int unsigned PosW   = 14;
  localparam int unsigned TexW   = 17;
  localparam int unsigned IdxW   = 19;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgSizeX    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSegsX    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSegsY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCentered = 3'd4;

  localparam logic [TexW-1:0] TexOne = 17'd65536;

  // job handed from the front end to the back end
  typedef struct packed {
    logic [SegW-1:0]  col;
    logic [SegW-1:0]  row;
    logic [IdxW-1:0]  base;
    logic             flip;
    logic             done;
  } job_t;

  typedef enum logic [2:0] {
    BE_IDLE, BE_DIVX, BE_DIVY, BE_QUO, BE_OUT
  } be_state_e;

endpackage

// ===== hdl/dgm_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module dgm_divider #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    logic [DenW:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = '0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
    end else if (cnt_q != '0) begin
      trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

// ===== hdl/dgm_front.sv =====
// Front end: accepts step words, walks the cell counters, queues jobs.
// Depends on dgm_pkg.
module dgm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic [dgm_pkg::SegW-1:0] cols_i,
  input  logic [dgm_pkg::SegW-1:0] rows_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic                  y_flip_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output dgm_pkg::job_t         job_o
);
  import dgm_pkg::*;

  logic [SegW-1:0] col_q, col_d, row_q, row_d, c, r;
  logic [IdxW-1:0] base_q, base_d;
  logic            empty, done, push, pop;
  job_t            q_mem_q [2];
  logic [1:0]      cnt_q, cnt_d;
  logic            wp_q, rp_q;
  job_t            nj;

  assign empty   = (cols_i == '0) || (rows_i == '0);
  assign ready_o = (cnt_q != 2'd2);
  assign push    = valid_i && ready_o && !empty;
  assign pop     = job_valid_o && job_ready_i;

  always_comb begin
    c = col_q;
    r = row_q;
    if (col_q >= cols_i || row_q >= rows_i) begin
      c = '0;
      r = '0;
    end
    done = (c == cols_i - 1'b1) && (r == rows_i - 1'b1);
    nj.col  = c;
    nj.row  = r;
    nj.base = (c == '0 && r == '0) ? '0 : base_q;
    nj.flip = y_flip_i;
    nj.done = done;
    col_d = col_q;
    row_d = row_q;
    base_d = base_q;
    if (restart_i) begin
      col_d = '0; row_d = '0; base_d = '0;
    end else if (push) begin
      if (done) begin
        col_d = '0; row_d = '0; base_d = '0;
      end else begin
        base_d = nj.base + IdxW'(5);
        if (r + 1'b1 >= rows_i) begin
          row_d = '0;
          col_d = c + 1'b1;
        end else begin
          row_d = r + 1'b1;
        end
      end
    end
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; base_q <= '0;
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      col_q <= col_d; row_q <= row_d; base_q <= base_d;
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= nj;
  end

  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem_q[rp_q];
endmodule

// ===== hdl/dgm_back.sv =====
// Back end: computes spacing and texture quotients, emits nine result words.
// Depends on dgm_pkg and dgm_divider.
module dgm_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [dgm_pkg::SizeW-1:0] sx_i,
  input  logic [dgm_pkg::SizeW-1:0] sy_i,
  input  logic [dgm_pkg::SegW-1:0]  nx_i,
  input  logic [dgm_pkg::SegW-1:0]  ny_i,
  input  logic [dgm_pkg::SegW-1:0]  hx_i,
  input  logic [dgm_pkg::SegW-1:0]  hy_i,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  dgm_pkg::job_t             job_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic                      kind_o,
  output logic signed [dgm_pkg::PosW-1:0] pos_x_o,
  output logic signed [dgm_pkg::PosW-1:0] pos_y_o,
  output logic [dgm_pkg::TexW-1:0]  tex_u_o,
  output logic [dgm_pkg::TexW-1:0]  tex_v_o,
  output logic [dgm_pkg::IdxW-1:0]  corner_a_o,
  output logic [dgm_pkg::IdxW-1:0]  corner_b_o,
  output logic [dgm_pkg::IdxW-1:0]  corner_c_o,
  output logic                      last_of_cell_o,
  output logic                      grid_done_o
);
  import dgm_pkg::*;
  localparam int unsigned NumW = 31;
  localparam int unsigned DenW = 13;

  be_state_e st_q, st_d;
  job_t      job_q;
  logic [3:0] k_q, k_d;     // quotient index / output index
  logic [SizeW-1:0] xs_q, ys_q;
  logic [TexW-1:0] tq_q [6];  // ul um ur vt vm vb
  logic div_start, div_busy, div_started_q;
  logic [NumW-1:0] div_num, div_quo;
  logic [DenW-1:0] div_den;

  dgm_divider #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  // numerators for the texture quotients: t_half*65536 + sz over 2*sz
  logic [SizeW+1:0] th;
  logic [SizeW-1:0] sz;
  always_comb begin
    logic [SizeW+9:0] tx, ty;
    tx = (SizeW+10)'(job_q.col) * (SizeW+10)'(xs_q);
    ty = (SizeW+10)'(job_q.row) * (SizeW+10)'(ys_q);
    th = '0;
    sz = (k_q < 4'd3) ? sx_i : sy_i;
    unique case (k_q)
      4'd0: th = (SizeW+2)'({tx, 1'b0});
      4'd1: th = (SizeW+2)'({tx, 1'b0} + xs_q);
      4'd2: th = (SizeW+2)'({tx, 1'b0} + {xs_q, 1'b0});
      4'd3: th = (SizeW+2)'({ty, 1'b0});
      4'd4: th = (SizeW+2)'({ty, 1'b0} + ys_q);
      4'd5: th = (SizeW+2)'({ty, 1'b0} + {ys_q, 1'b0});
      default: th = '0;
    endcase
  end

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (st_q)
      BE_DIVX: begin
        div_num = NumW'(sx_i); div_den = DenW'(nx_i);
      end
      BE_DIVY: begin
        div_num = NumW'(sy_i); div_den = DenW'(ny_i);
      end
      default: begin
        div_num = NumW'({th, 16'd0}) + NumW'(sz);
        div_den = {sz, 1'b0};
      end
    endcase
  end

  assign div_start = !div_started_q &&
                     (st_q == BE_DIVX || st_q == BE_DIVY || st_q == BE_QUO);

  always_comb begin
    st_d = st_q;
    k_d  = k_q;
    unique case (st_q)
      BE_IDLE: if (job_valid_i) st_d = BE_DIVX;
      BE_DIVX: if (div_started_q && !div_busy) st_d = BE_DIVY;
      BE_DIVY: if (div_started_q && !div_busy) begin
        st_d = BE_QUO; k_d = '0;
      end
      BE_QUO: if (div_started_q && !div_busy) begin
        if (k_q == 4'd5) begin
          st_d = BE_OUT; k_d = '0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      BE_OUT: if (ready_i) begin
        if (k_q == 4'd8) st_d = BE_IDLE;
        else k_d = k_q + 1'b1;
      end
      default: st_d = BE_IDLE;
    endcase
  end

  assign job_ready_o = (st_q == BE_IDLE);
  assign valid_o     = (st_q == BE_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BE_IDLE;
      k_q  <= '0;
      div_started_q <= 1'b0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
      if (st_d != st_q || k_d != k_q) div_started_q <= 1'b0;
      else if (div_start) div_started_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BE_IDLE && job_valid_i) job_q <= job_i;
    if (st_q == BE_DIVX && div_started_q && !div_busy) xs_q <= SizeW'(div_quo);
    if (st_q == BE_DIVY && div_started_q && !div_busy) ys_q <= SizeW'(div_quo);
    if (st_q == BE_QUO && div_started_q && !div_busy) tq_q[k_q[2:0]] <= TexW'(div_quo);
  end

  // output word
  always_comb begin
    logic signed [PosW+10:0] x0, y0, xo, yo;
    logic [TexW-1:0] tu, tv;
    logic [IdxW-1:0] b;
    x0 = ((PosW+11)'($signed({1'b0, job_q.col})) - (PosW+11)'($signed({1'b0, hx_i})))
         * $signed((PosW+11)'({xs_q, 1'b0}));
    y0 = ((PosW+11)'($signed({1'b0, job_q.row})) - (PosW+11)'($signed({1'b0, hy_i})))
         * $signed((PosW+11)'({ys_q, 1'b0}));
    xo = x0; yo = y0; tu = '0; tv = '0;
    b = job_q.base;
    kind_o = 1'b0;
    corner_a_o = '0; corner_b_o = '0; corner_c_o = '0;
    unique case (k_q)
      4'd0: begin
        xo = x0 + (PosW+11)'(xs_q); yo = y0 + (PosW+11)'(ys_q);
        tu = tq_q[1]; tv = tq_q[4];
      end
      4'd1: begin tu = tq_q[0]; tv = tq_q[3]; end
      4'd2: begin
        xo = x0 + (PosW+11)'({xs_q, 1'b0}); tu = tq_q[2]; tv = tq_q[3];
      end
      4'd3: begin
        yo = y0 + (PosW+11)'({ys_q, 1'b0}); tu = tq_q[0]; tv = tq_q[5];
      end
      4'd4: begin
        xo = x0 + (PosW+11)'({xs_q, 1'b0}); yo = y0 + (PosW+11)'({ys_q, 1'b0});
        tu = tq_q[2]; tv = tq_q[5];
      end
      4'd5: begin kind_o = 1'b1; corner_b_o = b + 2'd2; corner_c_o = b + 2'd1; end
      4'd6: begin kind_o = 1'b1; corner_b_o = b + 2'd1; corner_c_o = b + 2'd3; end
      4'd7: begin kind_o = 1'b1; corner_b_o = b + 2'd3; corner_c_o = b + 3'd4; end
      default: begin kind_o = 1'b1; corner_b_o = b + 3'd4; corner_c_o = b + 2'd2; end
    endcase
    if (kind_o) begin
      corner_a_o = b;
      pos_x_o = '0; pos_y_o = '0; tex_u_o = '0; tex_v_o = '0;
    end else begin
      pos_x_o = PosW'(xo);
      pos_y_o = PosW'(yo);
      tex_u_o = tu;
      tex_v_o = job_q.flip ? TexOne - tv : tv;
    end
    last_of_cell_o = (k_q == 4'd8);
    grid_done_o    = (k_q == 4'd8) && job_q.done;
  end
endmodule

// ===== hdl/diamond_grid_mesh_generator_top.sv =====
// Diamond grid mesh generator, top level.
// Each step word takes eight divides on one bit-serial divider (x/y spacing, six
// texture quotients), then the back end emits its nine result words.
// The back end takes the next job only when idle; ready_i low holds the back end,
// and the two-entry queue keeps taking step words until it is full.
// Reset (rst_ni low, async) restores register defaults and restarts the grid.
// Depends on dgm_pkg, dgm_front, dgm_back, dgm_divider.
module diamond_grid_mesh_generator_top #(
  parameter int unsigned MAX_SEGMENTS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [dgm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dgm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic valid_i,
  output logic ready_o,
  input  logic y_flip_i,
  output logic valid_o,
  input  logic ready_i,
  output logic kind_o,
  output logic signed [dgm_pkg::PosW-1:0] pos_x_o,
  output logic signed [dgm_pkg::PosW-1:0] pos_y_o,
  output logic [dgm_pkg::TexW-1:0] tex_u_o,
  output logic [dgm_pkg::TexW-1:0] tex_v_o,
  output logic [dgm_pkg::IdxW-1:0] corner_a_o,
  output logic [dgm_pkg::IdxW-1:0] corner_b_o,
  output logic [dgm_pkg::IdxW-1:0] corner_c_o,
  output logic last_of_cell_o,
  output logic grid_done_o
);
  import dgm_pkg::*;

  logic [SizeW-1:0] size_x_q, size_y_q, sx, sy;
  logic [SegW-1:0]  segs_x_q, segs_y_q, nx, ny, hx, hy, cols, rows;
  logic             centered_q, restart;
  logic             job_valid, job_ready;
  job_t             job;

  assign restart = cfg_we_i && (cfg_idx_i <= CfgCentered);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 12'd256; size_y_q <= 12'd256;
      segs_x_q <= 9'd16;   segs_y_q <= 9'd16;
      centered_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSizeX:    size_x_q <= cfg_data_i;
        CfgSizeY:    size_y_q <= cfg_data_i;
        CfgSegsX:    segs_x_q <= cfg_data_i[SegW-1:0];
        CfgSegsY:    segs_y_q <= cfg_data_i[SegW-1:0];
        CfgCentered: centered_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [SegW-1:0] eff_segs(input logic [SegW-1:0] s);
    if (s == '0) return SegW'(1);
    if (32'(s) > MAX_SEGMENTS) return SegW'(MAX_SEGMENTS);
    return s;
  endfunction

  assign sx   = (size_x_q == '0) ? SizeW'(1) : size_x_q;
  assign sy   = (size_y_q == '0) ? SizeW'(1) : size_y_q;
  assign nx   = eff_segs(segs_x_q);
  assign ny   = eff_segs(segs_y_q);
  assign hx   = centered_q ? (nx >> 1) : '0;
  assign hy   = centered_q ? (ny >> 1) : '0;
  assign cols = centered_q ? (hx << 1) : nx;
  assign rows = centered_q ? (hy << 1) : ny;

  dgm_front u_front (
    .clk_i, .rst_ni, .restart_i(restart), .cols_i(cols), .rows_i(rows),
    .valid_i, .ready_o, .y_flip_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  dgm_back u_back (
    .clk_i, .rst_ni, .sx_i(sx), .sy_i(sy), .nx_i(nx), .ny_i(ny),
    .hx_i(hx), .hy_i(hy),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .valid_o, .ready_i, .kind_o, .pos_x_o, .pos_y_o, .tex_u_o, .tex_v_o,
    .corner_a_o, .corner_b_o, .corner_c_o, .last_of_cell_o, .grid_done_o
  );
endmodule

// ===== tb/diamond_grid_mesh_generator_top_test.sv =====
// Self-checking testbench for diamond_grid_mesh_generator_top: directed table plus
// random config phases, checked word by word against a built-in cell predictor.
// Depends on dgm_pkg and the RTL of the mesh generator.
`timescale 1ns / 1ps

module diamond_grid_mesh_generator_top_test;
  import dgm_pkg::*;

  localparam logic KindVertex = 1'b0;
  localparam logic KindTri    = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgBadIdx = 3'd7;
  localparam int MaxSegs   = 256;
  localparam int SettleCyc = 400;
  localparam int NoMid     = -99999;

  typedef struct {
    logic                   kind;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [TexW-1:0]        tex_u;
    logic [TexW-1:0]        tex_v;
    logic [IdxW-1:0]        ca;
    logic [IdxW-1:0]        cb;
    logic [IdxW-1:0]        cc;
    logic                   last;
    logic                   done;
  } mesh_word_t;

  typedef struct {
    int sx, sy, nx, ny, cen;
    bit flip;
    int n;
    int mid_x, mid_y;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic valid_i, ready_o, y_flip_i;
  logic valid_o, ready_i;
  logic kind_o;
  logic signed [PosW-1:0] pos_x_o, pos_y_o;
  logic [TexW-1:0] tex_u_o, tex_v_o;
  logic [IdxW-1:0] corner_a_o, corner_b_o, corner_c_o;
  logic last_of_cell_o, grid_done_o;

  diamond_grid_mesh_generator_top u_dut (.*);

  // predictor copy of registers and cell walk
  int unsigned m_size_x, m_size_y, m_segs_x, m_segs_y, m_centered;
  int unsigned m_col, m_row, m_base;
  mesh_word_t  mesh_q[$];
  int errors, cells_sent, words_seen, grids_done, phases;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [TexW-1:0] tex_q16(longint t_half, longint sz);
    return TexW'((t_half * 65536 + sz) / (2 * sz));
  endfunction

  function automatic mesh_word_t vertex_word(int px, int py, logic [TexW-1:0] tu,
                                             logic [TexW-1:0] tv, bit flip);
    mesh_word_t w;
    w = '{default: '0};
    w.kind  = KindVertex;
    w.pos_x = PosW'(px);
    w.pos_y = PosW'(py);
    w.tex_u = tu;
    w.tex_v = flip ? TexOne - tv : tv;
    return w;
  endfunction

  function automatic mesh_word_t tri_word(int unsigned a, int unsigned b, int unsigned c);
    mesh_word_t w;
    w = '{default: '0};
    w.kind = KindTri;
    w.ca = IdxW'(a);
    w.cb = IdxW'(b);
    w.cc = IdxW'(c);
    return w;
  endfunction

  function automatic void restart_grid();
    m_col = 0;
    m_row = 0;
    m_base = 0;
  endfunction

  function automatic void predict_cell(bit flip);
    int sx, sy, nx, ny, xs, ys, hx, hy, cols, rows, c, r, x0, y0;
    int unsigned b;
    logic [TexW-1:0] ul, ur, um, vt, vb, vm;
    mesh_word_t w;
    bit done;
    sx = (m_size_x == 0) ? 1 : m_size_x;
    sy = (m_size_y == 0) ? 1 : m_size_y;
    nx = (m_segs_x == 0) ? 1 : (m_segs_x > MaxSegs ? MaxSegs : m_segs_x);
    ny = (m_segs_y == 0) ? 1 : (m_segs_y > MaxSegs ? MaxSegs : m_segs_y);
    xs = sx / nx;
    ys = sy / ny;
    hx = m_centered ? nx / 2 : 0;
    hy = m_centered ? ny / 2 : 0;
    cols = m_centered ? 2 * hx : nx;
    rows = m_centered ? 2 * hy : ny;
    if (cols == 0 || rows == 0) return;  // empty grid: no words
    if (m_col >= cols || m_row >= rows) restart_grid();
    c = m_col;
    r = m_row;
    b = m_base & 32'h7FFFF;
    x0 = 2 * (c - hx) * xs;
    y0 = 2 * (r - hy) * ys;
    ul = tex_q16(2 * c * xs, sx);
    ur = tex_q16(2 * c * xs + 2 * xs, sx);
    um = tex_q16(2 * c * xs + xs, sx);
    vt = tex_q16(2 * r * ys, sy);
    vb = tex_q16(2 * r * ys + 2 * ys, sy);
    vm = tex_q16(2 * r * ys + ys, sy);
    mesh_q.push_back(vertex_word(x0 + xs, y0 + ys, um, vm, flip));
    mesh_q.push_back(vertex_word(x0, y0, ul, vt, flip));
    mesh_q.push_back(vertex_word(x0 + 2 * xs, y0, ur, vt, flip));
    mesh_q.push_back(vertex_word(x0, y0 + 2 * ys, ul, vb, flip));
    mesh_q.push_back(vertex_word(x0 + 2 * xs, y0 + 2 * ys, ur, vb, flip));
    mesh_q.push_back(tri_word(b, b + 2, b + 1));
    mesh_q.push_back(tri_word(b, b + 1, b + 3));
    mesh_q.push_back(tri_word(b, b + 3, b + 4));
    w = tri_word(b, b + 4, b + 2);
    done = (c == cols - 1) && (r == rows - 1);
    w.last = 1'b1;
    w.done = done;
    mesh_q.push_back(w);
    if (done) begin
      restart_grid();
    end else begin
      m_base = (b + 5) & 32'h7FFFF;
      if (r + 1 >= rows) begin
        m_row = 0;
        m_col = c + 1;
      end else begin
        m_row = r + 1;
      end
    end
  endfunction

  // receiver: ready_i follows one of three stall modes, picked at random
  int unsigned stall_mode, rx_cyc;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_i <= 1'b0;
      rx_cyc <= 0;
      stall_mode <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: ready_i <= 1'b1;
        1: ready_i <= ($urandom_range(0, 9) < 6);
        default: ready_i <= (rx_cyc % 16) < 3;
      endcase
    end
  end

  always @(posedge clk_i) begin
    mesh_word_t e;
    if (rst_ni && valid_o && ready_i) begin
      words_seen++;
      if (mesh_q.size() == 0) begin
        $error("unexpected word: kind=%0d", kind_o);
        errors++;
      end else begin
        e = mesh_q.pop_front();
        if (e.done) grids_done++;
        if (kind_o !== e.kind) begin
          $error("kind: exp %0d got %0d", e.kind, kind_o); errors++;
        end
        if (pos_x_o !== e.pos_x) begin
          $error("pos_x: exp %0d got %0d", e.pos_x, pos_x_o); errors++;
        end
        if (pos_y_o !== e.pos_y) begin
          $error("pos_y: exp %0d got %0d", e.pos_y, pos_y_o); errors++;
        end
        if (tex_u_o !== e.tex_u) begin
          $error("tex_u: exp %0d got %0d", e.tex_u, tex_u_o); errors++;
        end
        if (tex_v_o !== e.tex_v) begin
          $error("tex_v: exp %0d got %0d", e.tex_v, tex_v_o); errors++;
        end
        if (corner_a_o !== e.ca) begin
          $error("corner_a: exp %0d got %0d", e.ca, corner_a_o); errors++;
        end
        if (corner_b_o !== e.cb) begin
          $error("corner_b: exp %0d got %0d", e.cb, corner_b_o); errors++;
        end
        if (corner_c_o !== e.cc) begin
          $error("corner_c: exp %0d got %0d", e.cc, corner_c_o); errors++;
        end
        if (last_of_cell_o !== e.last) begin
          $error("last_of_cell: exp %0d got %0d", e.last, last_of_cell_o); errors++;
        end
        if (grid_done_o !== e.done) begin
          $error("grid_done: exp %0d got %0d", e.done, grid_done_o); errors++;
        end
      end
    end
  end

  // sender bursts
  int burst_left;
  task automatic send_cell(bit flip);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
    end
    burst_left--;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i  <= 1'b1;
    y_flip_i <= flip;
    do @(posedge clk_i); while (!ready_o);
    predict_cell(flip);
    cells_sent++;
  endtask

  // idle the block: all words back, then let a possibly silent cell finish
  task automatic drain();
    valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (mesh_q.size() != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_cfg(int sx, int sy, int nx, int ny, int cen, bit bad_idx);
    logic [CfgIdxW-1:0] idx[5];
    int unsigned val[5];
    idx = '{CfgSizeX, CfgSizeY, CfgSegsX, CfgSegsY, CfgCentered};
    val = '{sx, sy, nx, ny, cen};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= CfgDataW'(val[i]);
      @(posedge clk_i);
    end
    if (bad_idx) begin
      // out-of-range index: ignored, no restart
      cfg_idx_i  <= CfgBadIdx;
      cfg_data_i <= CfgDataW'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    m_size_x = sx; m_size_y = sy; m_segs_x = nx; m_segs_y = ny; m_centered = cen;
    restart_grid();
    phases++;
  endtask

  dir_row_t dir_tab[$] = '{
    '{256, 256, 16, 16, 0, 0, 2, 16, 16},        // reset defaults
    '{4095, 4095, 256, 256, 0, 1, 3, 15, 15},
    '{1, 1, 256, 256, 0, 1, 2, 0, 0},            // zero spacing
    '{4095, 4095, 0, 0, 0, 0, 2, 4095, 4095},    // zero segs -> one cell
    '{4095, 4095, 511, 511, 0, 1, 2, 15, 15},    // segs saturate
    '{100, 100, 1, 1, 1, 0, 2, NoMid, NoMid},    // centered, empty grid
    '{300, 300, 3, 3, 1, 1, 5, -100, -100},      // odd count drops a row and a column
    '{0, 0, 1, 1, 0, 1, 2, 1, 1},                // zero size -> one
    '{4095, 4095, 256, 256, 1, 0, 3, -3825, -3825}
  };

  initial begin
    int n, qs, items;
    bit flip;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    valid_i = 1'b0; y_flip_i = 1'b0;
    errors = 0; cells_sent = 0; words_seen = 0; grids_done = 0; phases = 0;
    burst_left = 0;
    m_size_x = 256; m_size_y = 256; m_segs_x = 16; m_segs_y = 16; m_centered = 0;
    restart_grid();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (i > 0) begin
        drain();
        write_cfg(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].nx, dir_tab[i].ny,
                  dir_tab[i].cen, i == 3);
      end
      for (int k = 0; k < dir_tab[i].n; k++) begin
        qs = mesh_q.size();
        send_cell(dir_tab[i].flip ^ k[0]);
        if (k == 0 && dir_tab[i].mid_x != NoMid) begin
          if (mesh_q.size() != qs + 9 || mesh_q[qs].pos_x != dir_tab[i].mid_x ||
              mesh_q[qs].pos_y != dir_tab[i].mid_y) begin
            $error("table row %0d: midpoint exp (%0d,%0d)", i, dir_tab[i].mid_x,
                   dir_tab[i].mid_y);
            errors++;
          end
        end
      end
    end

    items = 0;
    while (items < 330) begin
      drain();
      case ($urandom_range(0, 5))
        0: write_cfg($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 511), $urandom_range(0, 511),
                     $urandom_range(0, 1), 1'($urandom_range(0, 1)));
        1: write_cfg($urandom_range(1, 4095), $urandom_range(1, 4095),
                     $urandom_range(1, 3), $urandom_range(1, 3), 1, 1'b0);
        default: write_cfg($urandom_range(1, 4095), $urandom_range(1, 4095),
                           $urandom_range(1, 6), $urandom_range(1, 6),
                           $urandom_range(0, 1), 1'b0);
      endcase
      n = $urandom_range(8, 40);
      for (int k = 0; k < n; k++) begin
        flip = 1'($urandom_range(0, 1));
        send_cell(flip);
        items++;
      end
    end

    drain();
    $display("Covered %0d cells over %0d config phases: %0d words, %0d full grids.",
             cells_sent, phases, words_seen, grids_done);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
